[hdl/oximeter_packet_parser_macros.svh]
// Assertion macros shared by the checker of the oximeter packet parser.
// Depends on nothing; the using scope must provide clk and rst_n.
`ifndef OXIMETER_PACKET_PARSER_MACROS_SVH
`define OXIMETER_PACKET_PARSER_MACROS_SVH

// Implication that must hold in the same cycle outside reset.
`define OPX_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("opx check failed: label");

// Implication that must hold in the cycle after the antecedent.
`define OPX_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("opx check failed: label");

`endif

[hdl/opx_pkg.sv]
// Package of the oximeter packet parser: frame constants, shared types and
// the decimal digit split. Depends on nothing.
package opx_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0] SYNC_MASK    = 8'hFC;
  localparam logic [7:0] SYNC_PATTERN = 8'h80;
  localparam int unsigned ALARM_BIT   = 3;
  localparam int unsigned MARK_BIT    = 7;
  localparam logic [8:0] PULSE_INVALID  = 9'd511;
  localparam logic [6:0] OXYGEN_INVALID = 7'd127;

  typedef enum logic [3:0] {
    POS_HUNT   = 4'b0001,
    POS_SECOND = 4'b0010,
    POS_THIRD  = 4'b0100,
    POS_FOURTH = 4'b1000
  } frame_pos_t;

  typedef struct packed {
    logic [8:0] heart_rate;
    logic [6:0] oxygen_level;
  } frame_t;

  typedef struct packed {
    logic [2:0] hundreds;
    logic [3:0] tens;
    logic [3:0] ones;
  } digits_t;

  function automatic digits_t dec_split(input logic [8:0] v);
    digits_t    d;
    logic [8:0] rem9;
    logic [6:0] rem;
    logic [14:0] prod;
    logic [6:0] tens_x10;
    priority if (v >= 9'd500) begin
      d.hundreds = 3'd5;
      rem9 = v - 9'd500;
    end else if (v >= 9'd400) begin
      d.hundreds = 3'd4;
      rem9 = v - 9'd400;
    end else if (v >= 9'd300) begin
      d.hundreds = 3'd3;
      rem9 = v - 9'd300;
    end else if (v >= 9'd200) begin
      d.hundreds = 3'd2;
      rem9 = v - 9'd200;
    end else if (v >= 9'd100) begin
      d.hundreds = 3'd1;
      rem9 = v - 9'd100;
    end else begin
      d.hundreds = 3'd0;
      rem9 = v;
    end
    rem = rem9[6:0];
    prod = 15'(rem) * 15'd205;
    d.tens = prod[14:11];
    tens_x10 = 7'(d.tens) * 7'd10;
    rem = rem - tens_x10;
    d.ones = rem[3:0];
    return d;
  endfunction

endpackage

[hdl/opx_front.sv]
// Front of the oximeter packet parser: frame hunt and field checks.
// Depends on opx_pkg; pushes checked frames into the queue.
module opx_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_rx_byte,
  input  logic            q_full,
  output logic            push,
  output opx_pkg::frame_t push_frame
);

  opx_pkg::frame_pos_t pos_r, pos_nxt;
  logic [1:0] high_r, high_nxt;
  logic [6:0] low_r, low_nxt;
  logic [6:0] oxy_r, oxy_nxt;
  logic       accept;
  logic [8:0] pulse;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign pulse    = {high_r, low_r};

  assign push_frame.heart_rate   = pulse;
  assign push_frame.oxygen_level = oxy_r;

  always_comb begin
    pos_nxt  = pos_r;
    high_nxt = high_r;
    low_nxt  = low_r;
    oxy_nxt  = oxy_r;
    push     = 1'b0;
    if (accept) begin
      unique case (pos_r)
        opx_pkg::POS_HUNT: begin
          if ((in_rx_byte & opx_pkg::SYNC_MASK) == opx_pkg::SYNC_PATTERN) begin
            high_nxt = in_rx_byte[1:0];
            pos_nxt  = opx_pkg::POS_SECOND;
          end
        end
        opx_pkg::POS_SECOND: begin
          if (in_rx_byte[opx_pkg::MARK_BIT]) begin
            pos_nxt = opx_pkg::POS_HUNT;
          end else begin
            low_nxt = in_rx_byte[6:0];
            pos_nxt = opx_pkg::POS_THIRD;
          end
        end
        opx_pkg::POS_THIRD: begin
          if (in_rx_byte[opx_pkg::MARK_BIT]) begin
            pos_nxt = opx_pkg::POS_HUNT;
          end else begin
            oxy_nxt = in_rx_byte[6:0];
            pos_nxt = opx_pkg::POS_FOURTH;
          end
        end
        opx_pkg::POS_FOURTH: begin
          pos_nxt = opx_pkg::POS_HUNT;
          push = !in_rx_byte[opx_pkg::ALARM_BIT] &&
                 (pulse != opx_pkg::PULSE_INVALID) &&
                 (oxy_r != opx_pkg::OXYGEN_INVALID);
        end
        default: begin
          pos_nxt = opx_pkg::POS_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= opx_pkg::POS_HUNT;
      high_r <= 2'd0;
      low_r  <= 7'd0;
      oxy_r  <= 7'd0;
    end else begin
      pos_r  <= pos_nxt;
      high_r <= high_nxt;
      low_r  <= low_nxt;
      oxy_r  <= oxy_nxt;
    end
  end

endmodule

[hdl/opx_queue.sv]
// Short frame queue between the front and the back of the parser.
// Depends on opx_pkg for the frame record type.
module opx_queue #(
  parameter int unsigned DEPTH = opx_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  opx_pkg::frame_t push_frame,
  input  logic            pop,
  output logic            full,
  output logic            not_empty,
  output opx_pkg::frame_t head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  opx_pkg::frame_t  entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = entry_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

[hdl/opx_back.sv]
// Back of the parser: decimal digit split and the output register.
// Depends on opx_pkg; takes frames from the head of the queue.
module opx_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_not_empty,
  input  opx_pkg::frame_t q_head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [8:0]      out_heart_rate,
  output logic [6:0]      out_oxygen_level,
  output logic [2:0]      out_pulse_hundreds,
  output logic [3:0]      out_pulse_tens,
  output logic [3:0]      out_pulse_ones,
  output logic [0:0]      out_oxygen_hundreds,
  output logic [3:0]      out_oxygen_tens,
  output logic [3:0]      out_oxygen_ones
);

  logic             valid_r;
  opx_pkg::frame_t  frame_r;
  opx_pkg::digits_t pdig_r, pdig_nxt;
  opx_pkg::digits_t odig_r, odig_nxt;

  assign pop      = q_not_empty && (!valid_r || !out_stall);
  assign pdig_nxt = opx_pkg::dec_split(q_head.heart_rate);
  assign odig_nxt = opx_pkg::dec_split({2'b00, q_head.oxygen_level});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!valid_r || !out_stall) begin
      valid_r <= q_not_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      frame_r <= q_head;
      pdig_r  <= pdig_nxt;
      odig_r  <= odig_nxt;
    end
  end

  assign out_valid           = valid_r;
  assign out_heart_rate      = frame_r.heart_rate;
  assign out_oxygen_level    = frame_r.oxygen_level;
  assign out_pulse_hundreds  = pdig_r.hundreds;
  assign out_pulse_tens      = pdig_r.tens;
  assign out_pulse_ones      = pdig_r.ones;
  assign out_oxygen_hundreds = odig_r.hundreds[0:0];
  assign out_oxygen_tens     = odig_r.tens;
  assign out_oxygen_ones     = odig_r.ones;

endmodule

[hdl/oximeter_packet_parser.sv]
// Top level of the oximeter packet parser: front, frame queue and back.
// Depends on opx_pkg, opx_front, opx_queue and opx_back.
//
//   Channel  Direction  Handshake            Payload
//   in       receive    in_valid / in_stall  in_rx_byte
//   out      send       out_valid/out_stall  pulse and oxygen values and digits
//
// One byte is taken in every cycle while the frame queue has room.
// A frame's result passes through the frame queue and the output register before it appears on out.
// Reset is synchronous and active low; it returns the hunt to the sync byte
// and empties the queue and the output register.
// A stall on out fills the queue of QUEUE_DEPTH frames, then stalls in.
module oximeter_packet_parser #(
  parameter int unsigned QUEUE_DEPTH = opx_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [8:0] out_heart_rate,
  output logic [6:0] out_oxygen_level,
  output logic [2:0] out_pulse_hundreds,
  output logic [3:0] out_pulse_tens,
  output logic [3:0] out_pulse_ones,
  output logic [0:0] out_oxygen_hundreds,
  output logic [3:0] out_oxygen_tens,
  output logic [3:0] out_oxygen_ones
);

  logic            q_full;
  logic            q_not_empty;
  logic            push;
  logic            pop;
  opx_pkg::frame_t push_frame;
  opx_pkg::frame_t q_head;

  opx_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .q_full     (q_full),
    .push       (push),
    .push_frame (push_frame)
  );

  opx_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_frame (push_frame),
    .pop        (pop),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  opx_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_not_empty         (q_not_empty),
    .q_head              (q_head),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_heart_rate      (out_heart_rate),
    .out_oxygen_level    (out_oxygen_level),
    .out_pulse_hundreds  (out_pulse_hundreds),
    .out_pulse_tens      (out_pulse_tens),
    .out_pulse_ones      (out_pulse_ones),
    .out_oxygen_hundreds (out_oxygen_hundreds),
    .out_oxygen_tens     (out_oxygen_tens),
    .out_oxygen_ones     (out_oxygen_ones)
  );

endmodule

[hdl/opx_checker.sv]
// Port checker of the oximeter packet parser, bound to the top level.
// Depends on oximeter_packet_parser_macros.svh and opx_pkg.
`include "oximeter_packet_parser_macros.svh"

module opx_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_rx_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic [8:0] out_heart_rate,
  input logic [6:0] out_oxygen_level,
  input logic [2:0] out_pulse_hundreds,
  input logic [3:0] out_pulse_tens,
  input logic [3:0] out_pulse_ones,
  input logic [0:0] out_oxygen_hundreds,
  input logic [3:0] out_oxygen_tens,
  input logic [3:0] out_oxygen_ones
);

  logic [10:0] pulse_sum;
  logic [10:0] oxygen_sum;
  logic        pulse_digits_ok;
  logic        oxygen_digits_ok;
  logic        reading_legal;

  assign pulse_sum = 11'(out_pulse_hundreds) * 11'd100 +
                     11'(out_pulse_tens) * 11'd10 + 11'(out_pulse_ones);
  assign oxygen_sum = 11'(out_oxygen_hundreds) * 11'd100 +
                      11'(out_oxygen_tens) * 11'd10 + 11'(out_oxygen_ones);

  assign pulse_digits_ok = (pulse_sum == 11'(out_heart_rate)) &&
                           (out_pulse_tens <= 4'd9) && (out_pulse_ones <= 4'd9);
  assign oxygen_digits_ok = (oxygen_sum == 11'(out_oxygen_level)) &&
                            (out_oxygen_tens <= 4'd9) && (out_oxygen_ones <= 4'd9);
  assign reading_legal = (out_heart_rate != opx_pkg::PULSE_INVALID) &&
                         (out_oxygen_level != opx_pkg::OXYGEN_INVALID);

  `OPX_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_heart_rate))
  `OPX_ASSERT_NOW(a_pulse_digits, out_valid, pulse_digits_ok)
  `OPX_ASSERT_NOW(a_oxygen_digits, out_valid, oxygen_digits_ok)
  `OPX_ASSERT_NOW(a_no_invalid, out_valid, reading_legal)

endmodule

bind oximeter_packet_parser opx_checker u_opx_checker (.*);
